[rtl/core/ebd_pkg.sv]
// shared types, constants and helpers of the envelope bucket detector
// no dependencies; imported by every module of the block
package ebd_pkg;

    localparam int WINDOW_DEF = 48;
    localparam int SAMPLE_W   = 16;
    localparam int THR_W      = 21;
    localparam int LEN_W      = 12;
    localparam int CNT_W      = 24;
    localparam int CFG_IDX_W  = 2;

    localparam logic [THR_W-1:0] THRESHOLD_RST  = THR_W'(149422);
    localparam logic [LEN_W-1:0] BUCKET_LEN_RST = LEN_W'(240);
    localparam logic [CNT_W-1:0] COUNT_MAX      = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_BUCKET_LEN = 2'd1
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first;
    } t_in_item;

    typedef struct packed {
        logic             heads;
        logic [CNT_W-1:0] heads_count;
        logic [CNT_W-1:0] bucket_count;
    } t_out_item;

    // per-cycle control handed from the top level to the datapath parts
    typedef struct packed {
        logic accept;
        logic first;
    } t_step;

    function automatic logic [SAMPLE_W-1:0] rectify(input logic signed [SAMPLE_W-1:0] s);
        // most negative sample maps to 2^15, which still fits
        return s[SAMPLE_W-1] ? (~s + SAMPLE_W'(1)) : s;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + CNT_W'(1);
    endfunction

endpackage

[rtl/core/envelope_bucket_detector.sv]
// envelope bucket detector: top level with configuration registers and handshake
// latency: a result is valid in the cycle after the item that closes its bucket
// throughput: one item per cycle when ready; delay line and sum update on accept
// input ready drops only while a result is held and not taken
// reset (synchronous, active low) clears control state, restores register defaults
// depends on ebd_pkg, ebd_window, ebd_bucket
module envelope_bucket_detector
    import ebd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]     i_cfg_data
);

    logic [THR_W-1:0]    r_threshold;
    logic [LEN_W-1:0]    r_bucket_len;
    logic                w_ready;
    t_step               w_step;
    logic [SAMPLE_W-1:0] w_mag;
    logic                w_loud;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RST;
            r_bucket_len <= BUCKET_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_THRESHOLD:  r_threshold  <= i_cfg_data;
                REG_BUCKET_LEN: r_bucket_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_ready       = !o_out_valid || i_out_ready;
    assign o_in_ready    = w_ready;
    assign w_step.accept = i_in_valid && w_ready;
    assign w_step.first  = i_in_data.first;
    assign w_mag         = rectify(i_in_data.sample);

    ebd_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_mag       (w_mag),
        .i_threshold (r_threshold),
        .o_loud      (w_loud)
    );

    ebd_bucket u_bucket (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_loud       (w_loud),
        .i_bucket_len (r_bucket_len),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule

[rtl/core/ebd_cell.sv]
// one stage of the rectified-sample delay line
// depends on ebd_pkg
module ebd_cell
    import ebd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [SAMPLE_W-1:0] i_mag,
    input  logic                i_vld,
    output logic [SAMPLE_W-1:0] o_mag,
    output logic                o_vld
);

    logic [SAMPLE_W-1:0] r_mag;
    logic                r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_mag <= i_mag;
        end
    end

    // an empty stage reads as zero
    assign o_mag = r_vld ? r_mag : '0;
    assign o_vld = r_vld;

endmodule

[rtl/core/ebd_window.sv]
// chain of delay cells plus the running sum of the window and the loud test
// depends on ebd_pkg and ebd_cell
module ebd_window
    import ebd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_step               i_step,
    input  logic [SAMPLE_W-1:0] i_mag,
    input  logic [THR_W-1:0]    i_threshold,
    output logic                o_loud
);

    localparam int SUM_W = $clog2(WINDOW * (2 ** (SAMPLE_W - 1)) + 1);
    localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

    logic [SAMPLE_W-1:0] w_in_mag  [WINDOW];
    logic                w_in_vld  [WINDOW];
    logic [SAMPLE_W-1:0] w_out_mag [WINDOW];
    logic                w_out_vld [WINDOW];

    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [SUM_W-1:0]    w_base;
    logic [SAMPLE_W-1:0] w_old;

    genvar k;
    generate
        for (k = 0; k < WINDOW; k++) begin : g_cell
            if (k == 0) begin : g_head
                assign w_in_mag[k] = i_mag;
                assign w_in_vld[k] = 1'b1;
            end else begin : g_body
                // a new recording empties the rest of the line
                assign w_in_mag[k] = w_out_mag[k-1];
                assign w_in_vld[k] = w_out_vld[k-1] & ~i_step.first;
            end
            ebd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_step.accept),
                .i_mag   (w_in_mag[k]),
                .i_vld   (w_in_vld[k]),
                .o_mag   (w_out_mag[k]),
                .o_vld   (w_out_vld[k])
            );
        end
    endgenerate

    always_comb begin
        w_base = i_step.first ? '0 : r_sum;
        w_old  = i_step.first ? '0 : w_out_mag[WINDOW-1];
        // the leaving value is part of the sum, so no underflow
        n_sum  = (w_base - SUM_W'(w_old)) + SUM_W'(i_mag);
        o_loud = CMP_W'(n_sum) > CMP_W'(i_threshold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_step.accept) begin
            r_sum <= n_sum;
        end
    end

endmodule

[rtl/core/ebd_bucket.sv]
// bucket position, loud flag, saturating totals and the result register
// depends on ebd_pkg
module ebd_bucket
    import ebd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_step            i_step,
    input  logic             i_loud,
    input  logic [LEN_W-1:0] i_bucket_len,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_out_item        o_out_data
);

    logic [LEN_W-1:0] r_pos;
    logic             r_exc;
    logic [CNT_W-1:0] r_heads;
    logic [CNT_W-1:0] r_buckets;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [LEN_W:0]   w_next;
    logic [LEN_W:0]   w_limit;
    logic             w_exc;
    logic             w_done;
    logic [CNT_W-1:0] w_heads;
    logic [CNT_W-1:0] w_buckets;

    always_comb begin
        w_next    = {1'b0, (i_step.first ? '0 : r_pos)} + (LEN_W + 1)'(1);
        // zero length acts as the full 4096 samples
        w_limit   = (i_bucket_len == '0) ? {1'b1, {LEN_W{1'b0}}} : {1'b0, i_bucket_len};
        w_exc     = (i_step.first ? 1'b0 : r_exc) | i_loud;
        w_done    = w_next >= w_limit;
        w_heads   = i_step.first ? '0 : r_heads;
        w_buckets = i_step.first ? '0 : r_buckets;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_exc       <= 1'b0;
            r_heads     <= '0;
            r_buckets   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_step.accept) begin
                if (w_done) begin
                    r_pos     <= '0;
                    r_exc     <= 1'b0;
                    r_buckets <= sat_inc(w_buckets);
                    r_heads   <= w_exc ? sat_inc(w_heads) : w_heads;
                end else begin
                    r_pos     <= w_next[LEN_W-1:0];
                    r_exc     <= w_exc;
                    r_buckets <= w_buckets;
                    r_heads   <= w_heads;
                end
            end
            if (i_step.accept && w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.accept && w_done) begin
            r_out.heads        <= w_exc;
            r_out.heads_count  <= w_exc ? sat_inc(w_heads) : w_heads;
            r_out.bucket_count <= sat_inc(w_buckets);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
